// File: sv/superio_config_register_port_top_defines.svh
// assertion macros for the super-i/o configuration register port
`ifndef SUPERIO_CONFIG_REGISTER_PORT_TOP_DEFINES_SVH
`define SUPERIO_CONFIG_REGISTER_PORT_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is asserted
`define SIO_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, disabled while reset is asserted
`define SIO_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SIO_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define SIO_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// File: sv/sio_pkg.sv
// shared types, constants and default table of the configuration register port
package sio_pkg;

    localparam int NUM_REGS_DEF = 42;

    localparam logic [7:0] UNLOCK_KEY   = 8'h55;
    localparam logic [7:0] LOCK_KEY     = 8'hAA;
    localparam logic [7:0] STATUS_READY = 8'h80;

    localparam logic [2:0] PORT_INDEX  = 3'd0;
    localparam logic [2:0] PORT_DATA   = 3'd1;
    localparam logic [2:0] PORT_STATUS = 3'd4;

    // memory access issued by the control stage
    typedef struct packed {
        logic       wr_en;
        logic       rd_en;
        logic [7:0] index;
        logic [7:0] wdata;
    } t_mem_req;

    // how the result byte is formed in the output stage
    typedef struct packed {
        logic       use_ram;
        logic [7:0] rbyte;
    } t_read_sel;

    // power-on value of each setting register
    function automatic logic [7:0] f_default(input logic [7:0] idx);
        logic [7:0] val;
        case (idx)
            8'h00:   val = 8'h28;
            8'h01:   val = 8'h9C;
            8'h02:   val = 8'h88;
            8'h03:   val = 8'h78;
            8'h06:   val = 8'hFF;
            8'h0D:   val = 8'h03;
            8'h0E:   val = 8'h02;
            8'h1E:   val = 8'h3C;
            8'h20:   val = 8'h3C;
            8'h21:   val = 8'h3C;
            8'h22:   val = 8'h3D;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

// File: sv/sio_ram.sv
// generic single-write, single-read ram with registered read data
module sio_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 42,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/sio_ctrl.sv
// unlock sequencer, index register, written flags and read decode
module sio_ctrl #(
    parameter int NUM_REGS = sio_pkg::NUM_REGS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic               i_action,
    input  logic [2:0]         i_port,
    input  logic [7:0]         i_wdata,
    output sio_pkg::t_mem_req  o_mem,
    output sio_pkg::t_read_sel o_sel
);

    import sio_pkg::*;

    localparam int         ADDR_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam logic [8:0] LIMIT  = 9'(NUM_REGS);

    typedef enum logic [1:0] {
        ST_LOCKED = 2'd0,
        ST_HALF   = 2'd1,
        ST_OPEN   = 2'd2
    } t_stage;

    t_stage              r_stage, n_stage;
    logic [7:0]          r_index, n_index;
    logic [NUM_REGS-1:0] r_written;

    logic              unlocked;
    logic              in_range;
    logic              written;
    logic              data_hit;
    logic              wr_hit;
    logic              rd_hit;
    logic [ADDR_W-1:0] addr;

    assign addr     = r_index[ADDR_W-1:0];
    assign unlocked = (r_stage == ST_OPEN);
    assign in_range = ({1'b0, r_index} < LIMIT);
    assign written  = in_range && r_written[addr];
    assign data_hit = unlocked && in_range && (i_port == PORT_DATA);
    assign wr_hit   = data_hit && i_action;
    assign rd_hit   = data_hit && !i_action;

    always_comb begin
        o_mem.wr_en = i_fire && wr_hit;
        o_mem.rd_en = i_fire && rd_hit && written;
        o_mem.index = r_index;
        o_mem.wdata = i_wdata;

        o_sel.use_ram = rd_hit && written;
        if (rd_hit) begin
            o_sel.rbyte = written ? 8'h00 : f_default(r_index);
        end else if (!i_action && (i_port == PORT_STATUS)) begin
            o_sel.rbyte = STATUS_READY;
        end else begin
            o_sel.rbyte = 8'h00;
        end
    end

    always_comb begin
        n_stage = r_stage;
        n_index = r_index;
        if (i_fire && i_action && (i_port == PORT_INDEX)) begin
            if (i_wdata == UNLOCK_KEY) begin
                case (r_stage)
                    ST_LOCKED: n_stage = ST_HALF;
                    ST_HALF:   n_stage = ST_OPEN;
                    default:   n_stage = r_stage;
                endcase
            end else if (i_wdata == LOCK_KEY) begin
                n_stage = ST_LOCKED;
            end else if (unlocked) begin
                n_index = i_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage   <= ST_LOCKED;
            r_index   <= 8'h00;
            r_written <= '0;
        end else begin
            r_stage <= n_stage;
            r_index <= n_index;
            if (o_mem.wr_en) begin
                r_written[addr] <= 1'b1;
            end
        end
    end

endmodule

// File: sv/superio_config_register_port_top.sv
// top level of the super-i/o configuration register port
//
//  channel | signals                            | request moves
//  --------+------------------------------------+------------------------------
//  input   | i_valid, o_stall, i_action/port/wd | one bus access (read/write)
//  output  | o_valid, i_stall, o_rdata          | one read-data byte per access
//
// one request per cycle sustained while i_stall is low; an accepted request shows
// on o_rdata and can be taken once it has passed the input register, then the
// control stage and the ram read port into the output register
// the setting ram has one write and one registered read port, both used by
// the control stage; a flag per entry makes unwritten entries read as default
// reset is synchronous and returns to locked, index 0, all entries at default
// i_stall holds the output register; the input register still takes one more
// request, and o_stall rises only when both stages are full and stalled
`include "superio_config_register_port_top_defines.svh"

module superio_config_register_port_top #(
    parameter int NUM_REGS = sio_pkg::NUM_REGS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_action,
    input  logic [2:0] i_port,
    input  logic [7:0] i_wdata,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_rdata
);

    import sio_pkg::*;

    localparam int ADDR_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    // input register
    logic       r_v1;
    logic       r_action;
    logic [2:0] r_port;
    logic [7:0] r_wdata;

    // output register (ram read data sits alongside it)
    logic       r_v2;
    logic       r_use_ram;
    logic [7:0] r_byte;

    logic       advance;
    logic       fire;
    logic       load;
    logic [7:0] ram_q;

    t_mem_req  mem;
    t_read_sel sel;

    // output stage can take a new result when empty or being drained
    assign advance = !r_v2 || !i_stall;
    assign fire    = r_v1 && advance;
    assign o_stall = r_v1 && !advance;
    assign load    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= load || (r_v1 && !fire);
            if (advance) begin
                r_v2 <= r_v1;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_action <= i_action;
            r_port   <= i_port;
            r_wdata  <= i_wdata;
        end
        if (fire) begin
            r_use_ram <= sel.use_ram;
            r_byte    <= sel.rbyte;
        end
    end

    sio_ctrl #(
        .NUM_REGS (NUM_REGS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_action (r_action),
        .i_port   (r_port),
        .i_wdata  (r_wdata),
        .o_mem    (mem),
        .o_sel    (sel)
    );

    // ram read only fires with the request, so its data holds under a stall
    sio_ram #(
        .WIDTH (8),
        .DEPTH (NUM_REGS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem.wr_en),
        .i_wr_addr (mem.index[ADDR_W-1:0]),
        .i_wr_data (mem.wdata),
        .i_rd_en   (mem.rd_en),
        .i_rd_addr (mem.index[ADDR_W-1:0]),
        .o_rd_data (ram_q)
    );

    assign o_valid = r_v2;
    assign o_rdata = r_use_ram ? ram_q : r_byte;

    `SIO_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall,
        "input stalled without a stalled full output")
    `SIO_ASSERT_NOW(a_empty_takes, i_clk, i_rst_n, !r_v1, !o_stall,
        "empty input register refused a request")
    `SIO_ASSERT_NEXT(a_write_zero, i_clk, i_rst_n, fire && r_action,
        o_valid && (o_rdata == 8'h00), "write request gave nonzero read data")
    `SIO_ASSERT_NEXT(a_status_read, i_clk, i_rst_n, fire && !r_action && (r_port == PORT_STATUS),
        o_valid && (o_rdata == STATUS_READY), "status read did not return ready")

endmodule
